// ===== hdl/sorted_set_insert_unit_assert.svh =====
// Assertion macros used by the sorted set insert unit top level.
`ifndef SORTED_SET_INSERT_UNIT_ASSERT_SVH
`define SORTED_SET_INSERT_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SSI_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SSI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SSI_ASSERT_IMPL(label, ante, cons)
`define SSI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/ssi_pkg.sv =====
// Types, codes and helper functions for the sorted set insert unit.
package ssi_pkg;

  localparam int ValueW = 32;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [2:0] ST_INSERTED     = 3'd0;
  localparam logic [2:0] ST_DUPLICATE    = 3'd1;
  localparam logic [2:0] ST_FULL         = 3'd2;
  localparam logic [2:0] ST_READ_OK      = 3'd3;
  localparam logic [2:0] ST_OUT_OF_RANGE = 3'd4;
  localparam logic [2:0] ST_CLEARED      = 3'd5;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic              shift;
    logic [ValueW-1:0] value;
  } ssi_bcast_t;

  // Data one cell hands to its upper neighbor.
  typedef struct packed {
    logic              lt;
    logic [ValueW-1:0] value;
  } ssi_link_t;

  // Signed ordering of two stored words.
  function automatic logic key_less(input logic [ValueW-1:0] a, input logic [ValueW-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

// ===== hdl/ssi_cell.sv =====
// One cell of the sorted chain: holds one entry, its compare flags and a read tap.
module ssi_cell
  import ssi_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int INDEX = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ssi_bcast_t                   bcast,
  input  logic [$clog2(DEPTH+1)-1:0]   count,
  input  logic [$clog2(DEPTH)-1:0]     rd_idx,
  input  ssi_link_t                    link_in,
  output ssi_link_t                    link_out,
  input  logic [ValueW-1:0]            rd_in,
  output logic [ValueW-1:0]            rd_out,
  output logic                         eq
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic [ValueW-1:0] value_r;
  logic [ValueW-1:0] value_nxt;
  logic              lt_r;
  logic              eq_r;
  logic [ValueW-1:0] rd_r;
  logic              occupied;

  assign occupied = CW'(INDEX) < count;

  // A cell keeps its word if it is below the new value, otherwise it takes the
  // new value when its lower neighbor stays, or the neighbor's word when that one moves up.
  always_comb begin
    if (lt_r) begin
      value_nxt = value_r;
    end else if (link_in.lt) begin
      value_nxt = bcast.value;
    end else begin
      value_nxt = link_in.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else begin
      lt_r <= occupied && key_less(value_r, bcast.value);
      eq_r <= occupied && (value_r == bcast.value);
    end
  end

  always_ff @(posedge clk) begin
    if (bcast.shift) begin
      value_r <= value_nxt;
    end
    rd_r <= (rd_idx == IW'(INDEX)) ? value_r : rd_in;
  end

  assign link_out = {lt_r, value_r};
  assign rd_out   = rd_r;
  assign eq       = eq_r;

endmodule

// ===== hdl/sorted_set_insert_unit.sv =====
// Top level of the sorted set insert unit: controller, counters and the row of cells.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall  | mode, new_value, position
//  out_    | output    | out_valid / out_stall| status, read_value, entry_count, smallest,
//          |           |                      | largest, is_empty
//  cfg_    | input     | cfg_valid / cfg_ready| ascending_order
//
// An insert or a clear beat goes from acceptance to a loaded result through a compare
// state, where every cell compares its word, an apply state for the shift or the clear,
// and a done state that loads the output register. A read beat instead waits in a read
// state while the read tap chain moves the selected word one cell per cycle to cell 0.
// Reset is synchronous and active low; it empties the set and selects ascending order.
// A stalled result sits in the output register while the next beat is already accepted;
// only the final load waits for that register to drain.
module sorted_set_insert_unit
  import ssi_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_mode,
  input  logic signed [31:0] in_new_value,
  input  logic [3:0]        in_position,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_status,
  output logic signed [31:0] out_read_value,
  output logic [4:0]        out_entry_count,
  output logic signed [31:0] out_smallest,
  output logic signed [31:0] out_largest,
  output logic              out_is_empty,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_ascending_order
);

`include "sorted_set_insert_unit_assert.svh"

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int PW = (CW > 4) ? CW : 4;
  localparam int EW = (CW > 5) ? CW : 5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_APPLY,
    S_READ,
    S_DONE
  } state_t;

  state_t            state_r;
  logic              asc_r;
  logic [CW-1:0]     count_r;
  logic [ValueW-1:0] largest_r;
  logic [2:0]        status_r;
  logic [1:0]        mode_r;
  logic [ValueW-1:0] value_r;
  logic [3:0]        pos_r;
  logic [IW-1:0]     rd_cnt_r;

  logic              out_valid_r;
  logic [2:0]        out_status_r;
  logic [ValueW-1:0] out_read_value_r;
  logic [4:0]        out_entry_count_r;
  logic [ValueW-1:0] out_smallest_r;
  logic [ValueW-1:0] out_largest_r;
  logic              out_is_empty_r;

  ssi_bcast_t        bcast;
  ssi_link_t         link_head;
  ssi_link_t         link_out [DEPTH];
  logic [ValueW-1:0] rd_chain [DEPTH+1];
  logic [DEPTH-1:0]  eq_vec;

  logic              in_accept;
  logic              out_free;
  logic              is_insert;
  logic              is_clear;
  logic              dup;
  logic              full;
  logic              ins_ok;
  logic [PW-1:0]     pos_ext;
  logic [PW-1:0]     cnt_ext;
  logic              in_range;
  logic [PW-1:0]     idx_full;
  logic [IW-1:0]     rd_idx;
  logic [EW-1:0]     cnt_w;
  logic [ValueW-1:0] largest_nxt;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign is_insert = (mode_r == MODE_INSERT);
  assign is_clear  = (mode_r == MODE_CLEAR);
  assign dup       = |eq_vec;
  assign full      = (count_r >= CW'(DEPTH));
  assign ins_ok    = is_insert && !dup && !full;

  // Read position mapped onto the ascending storage order.
  assign pos_ext  = PW'(pos_r);
  assign cnt_ext  = PW'(count_r);
  assign in_range = pos_ext < cnt_ext;
  assign idx_full = asc_r ? pos_ext : (cnt_ext - PW'(1) - pos_ext);
  assign rd_idx   = idx_full[IW-1:0];

  // The running maximum tracks the top entry, which no cell exposes at a fixed place.
  always_comb begin
    if (count_r == '0) begin
      largest_nxt = value_r;
    end else if (key_less(largest_r, value_r)) begin
      largest_nxt = value_r;
    end else begin
      largest_nxt = largest_r;
    end
  end

  assign bcast = {(state_r == S_APPLY) && ins_ok, value_r};

  // The bottom cell always sees a neighbor that stays put, so it takes the new value
  // whenever its own word is not below it.
  assign link_head       = {1'b1, {ValueW{1'b0}}};
  assign rd_chain[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ssi_cell #(
      .DEPTH (DEPTH),
      .INDEX (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .bcast    (bcast),
      .count    (count_r),
      .rd_idx   (rd_idx),
      .link_in  ((i == 0) ? link_head : link_out[(i == 0) ? 0 : i - 1]),
      .link_out (link_out[i]),
      .rd_in    (rd_chain[i+1]),
      .rd_out   (rd_chain[i]),
      .eq       (eq_vec[i])
    );
  end

  assign cnt_w = EW'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      asc_r       <= 1'b1;
      count_r     <= '0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        asc_r <= cfg_ascending_order;
      end
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            mode_r  <= in_mode;
            value_r <= in_new_value;
            pos_r   <= in_position;
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          rd_cnt_r <= '0;
          if (is_insert || is_clear) begin
            state_r <= S_APPLY;
          end else begin
            state_r <= S_READ;
          end
        end
        S_APPLY: begin
          if (is_clear) begin
            count_r  <= '0;
            status_r <= ST_CLEARED;
          end else if (dup) begin
            status_r <= ST_DUPLICATE;
          end else if (full) begin
            status_r <= ST_FULL;
          end else begin
            count_r   <= count_r + CW'(1);
            largest_r <= largest_nxt;
            status_r  <= ST_INSERTED;
          end
          state_r <= S_DONE;
        end
        S_READ: begin
          rd_cnt_r <= rd_cnt_r + IW'(1);
          if (rd_cnt_r == IW'(DEPTH - 1)) begin
            status_r <= in_range ? ST_READ_OK : ST_OUT_OF_RANGE;
            state_r  <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_status_r      <= status_r;
            out_read_value_r  <= (status_r == ST_READ_OK) ? rd_chain[0] : '0;
            out_entry_count_r <= cnt_w[4:0];
            out_smallest_r    <= (count_r != '0) ? link_out[0].value : '0;
            out_largest_r     <= (count_r != '0) ? largest_r : '0;
            out_is_empty_r    <= (count_r == '0);
            state_r           <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_read_value_r;
  assign out_entry_count = out_entry_count_r;
  assign out_smallest    = out_smallest_r;
  assign out_largest     = out_largest_r;
  assign out_is_empty    = out_is_empty_r;

  `SSI_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CW'(DEPTH))
  `SSI_ASSERT_NEXT(a_accept_starts, in_accept, state_r == S_CMP)
  `SSI_ASSERT_NEXT(a_insert_grows, (state_r == S_APPLY) && ins_ok, count_r == $past(count_r) + CW'(1))
  `SSI_ASSERT_NEXT(a_clear_empties, (state_r == S_APPLY) && is_clear, count_r == '0)
  `SSI_ASSERT_IMPL(a_no_dup_full_shift, bcast.shift, !dup && !full)

endmodule

// ===== tb/sorted_set_checker.sv =====
`timescale 1ns / 100ps
// Watches the sorted set insert unit's channels, predicts every result and compares it.
module sorted_set_checker
  import ssi_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic signed [31:0] in_new_value,
  input  logic [3:0]         in_position,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         out_status,
  input  logic signed [31:0] out_read_value,
  input  logic [4:0]         out_entry_count,
  input  logic signed [31:0] out_smallest,
  input  logic signed [31:0] out_largest,
  input  logic               out_is_empty,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_ascending_order,
  output int                 mismatch_count,
  output int                 results_pending
);

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] read_value;
    logic [4:0]         entry_count;
    logic signed [31:0] smallest;
    logic signed [31:0] largest;
    logic               is_empty;
  } set_result_t;

  // The words are always held in increasing signed order; the order register
  // only decides how a read position maps onto them.
  logic [31:0] set_words [DEPTH];
  int          word_count;
  logic        ascending;
  set_result_t expected_results [$];
  set_result_t seen;
  set_result_t want;

  function automatic set_result_t next_set_result(input logic [1:0] mode,
                                                  input logic [31:0] value,
                                                  input logic [3:0] pos);
    set_result_t res;
    int slot;
    int j;
    int idx;
    res = '0;
    if (mode == MODE_INSERT) begin
      slot = 0;
      while (slot < word_count && $signed(set_words[slot]) < $signed(value)) slot++;
      if (slot < word_count && set_words[slot] == value) begin
        res.status = ST_DUPLICATE;
      end else if (word_count >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        for (j = word_count; j > slot; j--) set_words[j] = set_words[j-1];
        set_words[slot] = value;
        word_count++;
        res.status = ST_INSERTED;
      end
    end else if (mode == MODE_CLEAR) begin
      word_count = 0;
      res.status = ST_CLEARED;
    end else begin
      // Any other mode, the unused code included, reads.
      if (int'(pos) < word_count) begin
        idx = ascending ? int'(pos) : word_count - 1 - int'(pos);
        res.read_value = set_words[idx];
        res.status = ST_READ_OK;
      end else begin
        res.status = ST_OUT_OF_RANGE;
      end
    end
    res.entry_count = 5'(word_count);
    if (word_count != 0) begin
      res.smallest = set_words[0];
      res.largest = set_words[word_count-1];
    end
    res.is_empty = (word_count == 0);
    return res;
  endfunction

  initial begin
    mismatch_count = 0;
    results_pending = 0;
    ascending = 1'b1;
    word_count = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      ascending = 1'b1;
      word_count = 0;
      expected_results.delete();
    end else begin
      // The result side is checked before this edge's input beat is predicted,
      // since a result can never belong to a beat taken at the same edge.
      if (out_valid && !out_stall) begin
        seen = '{out_status, out_read_value, out_entry_count, out_smallest,
                 out_largest, out_is_empty};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result beat with nothing expected: status=%0d read=%0d", $time,
                     seen.status, seen.read_value);
        end else begin
          want = expected_results.pop_front();
          if (seen.status !== want.status || seen.read_value !== want.read_value ||
              seen.entry_count !== want.entry_count || seen.smallest !== want.smallest ||
              seen.largest !== want.largest || seen.is_empty !== want.is_empty) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: expected status=%0d read=%0d count=%0d min=%0d max=%0d empty=%0b",
                       $time, want.status, want.read_value, want.entry_count, want.smallest,
                       want.largest, want.is_empty);
              $display("%0t: actual   status=%0d read=%0d count=%0d min=%0d max=%0d empty=%0b",
                       $time, seen.status, seen.read_value, seen.entry_count, seen.smallest,
                       seen.largest, seen.is_empty);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) ascending = cfg_ascending_order;
      if (in_valid && !in_stall)
        expected_results.push_back(next_set_result(in_mode, in_new_value, in_position));
    end
    results_pending = expected_results.size();
  end

endmodule

// ===== tb/sorted_set_insert_unit_tb.sv =====
`timescale 1ns / 100ps
// Top of the sorted set insert unit testbench: clock, reset, stimulus and the verdict.
module sorted_set_insert_unit_tb
  import ssi_pkg::*;
;

  localparam int DEPTH = 16;
  // The mode field has one code left over, which the block treats as a read.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // A read beat is the slowest, as it walks the read tap chain; the drain leaves margin so
  // that any stray result shows up before the next phase or the verdict.
  localparam int DRAIN_CYCLES = DEPTH + 12;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_BEATS = 310;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_mode = MODE_INSERT;
  logic signed [31:0] in_new_value = '0;
  logic [3:0]        in_position = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        out_status;
  logic signed [31:0] out_read_value;
  logic [4:0]        out_entry_count;
  logic signed [31:0] out_smallest;
  logic signed [31:0] out_largest;
  logic              out_is_empty;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_ascending_order = 1'b1;

  int                mismatch_count;
  int                results_pending;

  // Idle rates in percent. The sender's rate is read only by the stimulus
  // process itself; the receiver's rate is handed over with a nonblocking write.
  int                send_idle_pct = 27;
  int                recv_idle_pct = 58;

  // A single long hold-off of the result side, requested once by the stimulus.
  logic              hold_req = 1'b0;
  logic              hold_taken = 1'b0;
  int                hold_left = 0;

  always #5 clk = ~clk;

  sorted_set_insert_unit #(.DEPTH(DEPTH)) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_new_value       (in_new_value),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_read_value     (out_read_value),
    .out_entry_count    (out_entry_count),
    .out_smallest       (out_smallest),
    .out_largest        (out_largest),
    .out_is_empty       (out_is_empty),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_ascending_order(cfg_ascending_order)
  );

  sorted_set_checker #(.DEPTH(DEPTH)) set_watch (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_new_value       (in_new_value),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_read_value     (out_read_value),
    .out_entry_count    (out_entry_count),
    .out_smallest       (out_smallest),
    .out_largest        (out_largest),
    .out_is_empty       (out_is_empty),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_ascending_order(cfg_ascending_order),
    .mismatch_count     (mismatch_count),
    .results_pending    (results_pending)
  );

  // The result side stalls at random. Once the stimulus asks for it, it holds
  // off in one long unbroken stall so that the block backs up and has to
  // stall its input while the sender keeps offering beats.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offers one beat and returns at the edge that takes it. Idle cycles come
  // first so that gaps land in front of any beat, whatever the block is doing.
  // Valid stays high after the beat, so back-to-back beats never drop it.
  task automatic send_beat(input logic [1:0] mode, input logic [31:0] value,
                           input logic [3:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_new_value <= value;
    in_position <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drops valid, waits until every predicted result has come back, then lets
  // the block settle for longer than its slowest beat. Polling on the falling
  // edge keeps the read clear of the checker's update at the rising edge.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes the order register; only called while the block is idle.
  task automatic write_order(input logic ascending);
    cfg_valid <= 1'b1;
    cfg_ascending_order <= ascending;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Values come from a narrow band often enough to hit duplicates, from the
  // extremes of the signed range now and then, and otherwise from all 32 bits.
  function automatic logic [31:0] pick_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) return 32'($signed($urandom_range(16)) - 8);
    if (pick < 40) begin
      case ($urandom_range(3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  // Most of the random traffic is made of runs: an optional clear, a burst of
  // inserts long enough to fill the set at times, then a few reads in either
  // read code. The remainder is loose beats with any mode.
  task automatic run_random(input int beats);
    int sent;
    int burst;
    sent = 0;
    while (sent < beats) begin
      if ($urandom_range(99) < 75) begin
        if ($urandom_range(1)) begin
          send_beat(MODE_CLEAR, $urandom, 4'($urandom));
          sent++;
        end
        burst = $urandom_range(20, 1);
        repeat (burst) begin
          send_beat(MODE_INSERT, pick_value(), 4'($urandom));
          sent++;
        end
        burst = $urandom_range(10, 2);
        repeat (burst) begin
          send_beat(($urandom_range(3) == 0) ? MODE_UNUSED : MODE_READ, $urandom,
                    4'($urandom));
          sent++;
        end
      end else begin
        burst = $urandom_range(6, 1);
        repeat (burst) begin
          send_beat(2'($urandom_range(3)), pick_value(), 4'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    int phase;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening in the reset order (ascending). It reads an empty set,
    // inserts both ends of the signed range, zero and its neighbors, repeats a
    // value, reads inside and past the count with both read codes, then fills
    // the set to the top and offers a new value and a repeated one while full.
    send_beat(MODE_CLEAR, 32'h0, 4'd0);
    send_beat(MODE_READ, 32'h0, 4'd0);
    send_beat(MODE_INSERT, 32'h7fff_ffff, 4'd15);
    send_beat(MODE_INSERT, 32'h8000_0000, 4'd0);
    send_beat(MODE_INSERT, 32'h0000_0000, 4'd0);
    send_beat(MODE_INSERT, 32'hffff_ffff, 4'd0);
    send_beat(MODE_INSERT, 32'h0000_0001, 4'd0);
    send_beat(MODE_INSERT, 32'h8000_0000, 4'd0);
    send_beat(MODE_READ, 32'hffff_ffff, 4'd0);
    send_beat(MODE_READ, 32'h0, 4'd4);
    send_beat(MODE_READ, 32'h0, 4'd5);
    send_beat(MODE_UNUSED, 32'h0, 4'd15);
    for (int v = 100; v <= 110; v++) send_beat(MODE_INSERT, 32'(v), 4'd0);
    send_beat(MODE_INSERT, 32'd200, 4'd0);
    send_beat(MODE_INSERT, 32'h0000_0000, 4'd0);
    send_beat(MODE_READ, 32'h0, 4'd15);
    wait_drained();

    // Three phases, each opened by an order write on an idle block. The set
    // is left as it is across the write, so reads switch direction on stored
    // data. The idle pattern moves from a slow receiver to a slow sender and
    // then to full rate, where the long hold-off is requested.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          write_order(1'b0);
          send_idle_pct = 27;
          recv_idle_pct <= 58;
        end
        1: begin
          write_order(1'b1);
          send_idle_pct = 58;
          recv_idle_pct <= 27;
        end
        default: begin
          write_order(1'($urandom_range(1)));
          send_idle_pct = 0;
          recv_idle_pct <= 0;
          hold_req <= 1'b1;
        end
      endcase
      run_random(PHASE_BEATS);
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("[sorted_set_insert_unit] OK");
    end else begin
      $display("[sorted_set_insert_unit] ERROR");
    end
    $finish;
  end

  // The normal run takes well under a tenth of this, even with every read at
  // its full latency behind the slowest receiver.
  initial begin
    #(8_000_000);
    $display("[sorted_set_insert_unit] ERROR");
    $finish;
  end

endmodule
